@@ hw/rtl/lbc_pkg.sv @@
package lbc_pkg;

   localparam int ENTRIES_DEF  = 16;
   localparam int KEY_BITS_DEF = 16;
   localparam int CFG_BITS     = 5;
   localparam int KEY_IN_BITS  = 16;
   localparam int DATA_BITS    = 8;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_DECIDE,
      ST_AGE,
      ST_AGE_END,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan_rd;
      logic decide;
      logic age_rd;
      logic respond;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic key_zero;
      logic last;
      logic hit;
      logic put;
      logic out_busy;
   } dp_sts_type;

endpackage

@@ hw/rtl/lbc_ctrl.sv @@
module lbc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  lbc_pkg::dp_sts_type sts,
   output lbc_pkg::dp_cmd_type cmd
);
   import lbc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = sts.key_zero ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            // a get that misses leaves the recency order alone
            state_in = (sts.put || sts.hit) ? ST_AGE : ST_DONE;
         end
         ST_AGE: begin
            if (sts.last) begin
               state_in = ST_AGE_END;
            end
         end
         ST_AGE_END: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!sts.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
         end
         ST_AGE: begin
            cmd.age_rd = 1'b1;
         end
         ST_DONE: begin
            cmd.respond = !sts.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_decide_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> ($past(state_ff) == ST_SCAN_END))
      else $error("decide entered without a finished scan");

   a_age_only_touch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AGE) |-> (sts.hit || sts.put))
      else $error("recency update on a get miss");

   a_ready_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !sts.out_busy) |=> req_tready)
      else $error("not ready after result handed over");
`endif

endmodule

@@ hw/rtl/lbc_datapath.sv @@
module lbc_datapath #(
   parameter int ENTRIES  = lbc_pkg::ENTRIES_DEF,
   parameter int KEY_BITS = lbc_pkg::KEY_BITS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           csr_we,
   input  logic [lbc_pkg::CFG_BITS-1:0]                   csr_wdata,
   input  logic [lbc_pkg::KEY_IN_BITS+lbc_pkg::DATA_BITS-1:0] req_tdata,
   input  logic                                           req_tuser,
   input  logic                                           rsp_tready,
   output logic                                           rsp_tvalid,
   output logic [lbc_pkg::DATA_BITS-1:0]                  rsp_tdata,
   output logic                                           rsp_tuser,
   input  lbc_pkg::dp_cmd_type                            cmd,
   output lbc_pkg::dp_sts_type                            sts
);
   import lbc_pkg::*;

   localparam int IdxBits  = $clog2(ENTRIES);
   localparam int CntBits  = $clog2(ENTRIES + 1);
   localparam int RankBits = IdxBits;
   localparam int InBits   = (KEY_BITS > KEY_IN_BITS) ? KEY_BITS : KEY_IN_BITS;
   localparam int CmpBits  = (CntBits > CFG_BITS) ? CntBits : CFG_BITS;

   // storage
   logic [KEY_BITS-1:0]  key_mem  [ENTRIES];
   logic [DATA_BITS-1:0] byte_mem [ENTRIES];
   logic [RankBits-1:0]  rank_mem [ENTRIES];
   logic [ENTRIES-1:0]   valid_ff;
   logic [ENTRIES-1:0]   rset_ff;

   // active entry count
   logic [CntBits-1:0] entries_ff;
   logic [CntBits-1:0] entries_in;
   logic [CmpBits-1:0] wr_ext;

   // request
   logic [InBits-1:0]    key_ext;
   logic [KEY_BITS-1:0]  key_m;
   logic                 put_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic [DATA_BITS-1:0] data_ff;

   // sweep pointer
   logic [CntBits-1:0] ptr_ff;
   logic [IdxBits-1:0] addr;
   logic               last;

   // read stage
   logic                 scan_vld_ff;
   logic                 age_vld_ff;
   logic [IdxBits-1:0]   rd_idx_ff;
   logic [KEY_BITS-1:0]  rd_key_ff;
   logic [DATA_BITS-1:0] rd_byte_ff;
   logic [RankBits-1:0]  rd_rank_ff;
   logic                 rd_rset_ff;
   logic                 rd_valid_ff;
   logic [RankBits-1:0]  rank_eff;

   // search results
   logic                 hit_ff;
   logic                 free_ff;
   logic [IdxBits-1:0]   found_idx_ff;
   logic [RankBits-1:0]  found_rank_ff;
   logic [DATA_BITS-1:0] found_byte_ff;
   logic [IdxBits-1:0]   free_idx_ff;
   logic [RankBits-1:0]  free_rank_ff;
   logic [IdxBits-1:0]   old_idx_ff;
   logic [RankBits-1:0]  old_rank_ff;

   // chosen slot
   logic [IdxBits-1:0]  slot_in;
   logic [RankBits-1:0] slot_rank_in;
   logic [IdxBits-1:0]  slot_ff;
   logic [RankBits-1:0] slot_rank_ff;

   // ageing write
   logic                age_wr;
   logic [RankBits-1:0] age_val;

   // output register
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [DATA_BITS-1:0] rsp_data_ff;

   assign wr_ext = CmpBits'(csr_wdata);

   always_comb begin
      if (wr_ext == '0) begin
         entries_in = CntBits'(1);
      end else if (wr_ext > CmpBits'(ENTRIES)) begin
         entries_in = CntBits'(ENTRIES);
      end else begin
         entries_in = wr_ext[CntBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= CntBits'(ENTRIES);
      end else if (csr_we) begin
         entries_ff <= entries_in;
      end
   end

   assign key_ext = InBits'(req_tdata[KEY_IN_BITS-1:0]);
   assign key_m   = key_ext[KEY_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         put_ff  <= (req_tuser == CMD_PUT);
         key_ff  <= key_m;
         data_ff <= req_tdata[KEY_IN_BITS +: DATA_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else if (cmd.load || cmd.decide) begin
         ptr_ff <= '0;
      end else if (cmd.scan_rd || cmd.age_rd) begin
         ptr_ff <= ptr_ff + CntBits'(1);
      end
   end

   assign addr = ptr_ff[IdxBits-1:0];
   assign last = (ptr_ff == entries_ff - CntBits'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_vld_ff <= 1'b0;
         age_vld_ff  <= 1'b0;
      end else begin
         scan_vld_ff <= cmd.scan_rd;
         age_vld_ff  <= cmd.age_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_rd || cmd.age_rd) begin
         rd_idx_ff   <= addr;
         rd_rset_ff  <= rset_ff[addr];
         rd_valid_ff <= valid_ff[addr];
      end
   end

   // ranks not yet written read as their entry index
   assign rank_eff = rd_rset_ff ? rd_rank_ff : RankBits'(rd_idx_ff);

   always_comb begin
      if (hit_ff) begin
         slot_in      = found_idx_ff;
         slot_rank_in = found_rank_ff;
      end else if (free_ff) begin
         slot_in      = free_idx_ff;
         slot_rank_in = free_rank_ff;
      end else begin
         slot_in      = old_idx_ff;
         slot_rank_in = old_rank_ff;
      end
   end

   assign age_wr  = age_vld_ff && ((rd_idx_ff == slot_ff) || (rank_eff < slot_rank_ff));
   assign age_val = (rd_idx_ff == slot_ff) ? '0 : rank_eff + RankBits'(1);

   // memories: one read address and one write address per cycle
   always_ff @(posedge clock) begin
      if (cmd.scan_rd || cmd.age_rd) begin
         rd_key_ff  <= key_mem[addr];
         rd_byte_ff <= byte_mem[addr];
         rd_rank_ff <= rank_mem[addr];
      end
      if (cmd.decide && put_ff) begin
         byte_mem[slot_in] <= data_ff;
         if (!hit_ff) begin
            key_mem[slot_in] <= key_ff;
         end
      end
      if (age_wr) begin
         rank_mem[rd_idx_ff] <= age_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         valid_ff <= '0;
      end else if (cmd.decide && put_ff && !hit_ff) begin
         valid_ff[slot_in] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         rset_ff <= '0;
      end else if (age_wr) begin
         rset_ff[rd_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (cmd.load) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (scan_vld_ff) begin
         if (!hit_ff && rd_valid_ff && (rd_key_ff == key_ff)) begin
            hit_ff <= 1'b1;
         end
         if (!free_ff && !rd_valid_ff) begin
            free_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         old_idx_ff  <= '0;
         old_rank_ff <= '0;
      end else if (scan_vld_ff) begin
         if (!hit_ff && rd_valid_ff && (rd_key_ff == key_ff)) begin
            found_idx_ff  <= rd_idx_ff;
            found_rank_ff <= rank_eff;
            found_byte_ff <= rd_byte_ff;
         end
         if (!free_ff && !rd_valid_ff) begin
            free_idx_ff  <= rd_idx_ff;
            free_rank_ff <= rank_eff;
         end
         // ties go to the later entry
         if (rank_eff >= old_rank_ff) begin
            old_idx_ff  <= rd_idx_ff;
            old_rank_ff <= rank_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         slot_ff      <= slot_in;
         slot_rank_ff <= slot_rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_hit_ff  <= hit_ff;
         rsp_data_ff <= (hit_ff && !put_ff) ? found_byte_ff : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

   assign sts.key_zero = (key_m == '0);
   assign sts.last     = last;
   assign sts.hit      = hit_ff;
   assign sts.put      = put_ff;
   assign sts.out_busy = rsp_valid_ff && !rsp_tready;

`ifndef SYNTHESIS
   a_fill_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && put_ff && !hit_ff && !csr_we) |=> valid_ff[$past(slot_in)])
      else $error("filled entry not marked valid");

   a_phases_apart: assert property (@(posedge clock) disable iff (reset)
      !(scan_vld_ff && age_vld_ff))
      else $error("scan and ageing reads overlap");

   a_no_zero_key_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |-> !(hit_ff && (key_ff == '0)))
      else $error("hit reported for key zero");

   a_entries_nonzero: assert property (@(posedge clock) disable iff (reset)
      (entries_ff != '0) && (entries_ff <= CntBits'(ENTRIES)))
      else $error("active entry count out of range");
`endif

endmodule

@@ hw/rtl/lru_block_cache.sv @@
// channel  | valid / ready         | payload
// ---------+-----------------------+---------------------------------------------
// request  | req_tvalid/req_tready | req_tuser = cmd, req_tdata = key, data_in
// response | rsp_tvalid/rsp_tready | rsp_tuser = hit, rsp_tdata = data_out
// csr      | csr_we                | csr_wdata = entries_in_use
//
// a put or a get hit makes a lookup sweep and then a recency-rank update sweep over the
// n active entries, a get miss makes only the lookup sweep, and key zero makes neither;
// each sweep makes one read of the entry memories per cycle.
// a new request is not taken until the result has gone into the output register.
// reset (synchronous) empties the cache with no clearing pass; a csr write does the same.
// a finished result waits in the output register while the next request is taken.
module lru_block_cache #(
   parameter int ENTRIES  = lbc_pkg::ENTRIES_DEF,
   parameter int KEY_BITS = lbc_pkg::KEY_BITS_DEF
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               csr_we,
   input  logic [lbc_pkg::CFG_BITS-1:0]                       csr_wdata,
   input  logic                                               req_tvalid,
   output logic                                               req_tready,
   // key [15:0], data_in [23:16]
   input  logic [lbc_pkg::KEY_IN_BITS+lbc_pkg::DATA_BITS-1:0] req_tdata,
   // cmd
   input  logic                                               req_tuser,
   output logic                                               rsp_tvalid,
   input  logic                                               rsp_tready,
   // data_out [7:0]
   output logic [lbc_pkg::DATA_BITS-1:0]                      rsp_tdata,
   // hit
   output logic                                               rsp_tuser
);
   import lbc_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   lbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lbc_datapath #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

@@ dv/lru_block_cache_tb.sv @@
`timescale 1ns / 1ps

module lru_block_cache_tb;
   import lbc_pkg::*;

   localparam int LINES      = ENTRIES_DEF;
   localparam int RANK_W     = $clog2(LINES);
   localparam int LONG_HOLD  = 400;
   localparam int IDLE_LIMIT = 5000;
   localparam int RANDOM_REQS = 1550;

   typedef struct packed {
      logic                   cmd;
      logic [KEY_IN_BITS-1:0] key;
      logic [DATA_BITS-1:0]   data_in;
   } cache_req_type;

   typedef struct packed {
      logic                   cmd;
      logic [KEY_IN_BITS-1:0] key;
      logic                   hit;
      logic [DATA_BITS-1:0]   data_out;
   } cache_rsp_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             csr_we     = 1'b0;
   logic [CFG_BITS-1:0]              csr_wdata  = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [KEY_IN_BITS+DATA_BITS-1:0] req_tdata  = '0;
   logic                             req_tuser  = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [DATA_BITS-1:0]             rsp_tdata;
   logic                             rsp_tuser;

   lru_block_cache dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   cache_req_type pending_reqs [$];
   cache_rsp_type expected_rsps [$];
   int            mismatches = 0;
   logic          quiet_gaps = 1'b0;

   logic [CFG_BITS-1:0] sweep_settings [6] = '{5'd17, 5'd1, 5'd31, 5'd2, 5'd16, 5'd9};

   // shadow of the cache contents
   logic                   line_valid [LINES];
   logic [KEY_IN_BITS-1:0] line_key   [LINES];
   logic [DATA_BITS-1:0]   line_data  [LINES];
   logic [RANK_W-1:0]      line_age   [LINES];
   logic [CFG_BITS-1:0]    ways_setting = CFG_BITS'(LINES);

   function automatic int ways_active();
      if (ways_setting == 0) return 1;
      if (ways_setting > LINES) return LINES;
      return ways_setting;
   endfunction

   function automatic void flush_lines();
      for (int i = 0; i < LINES; i++) begin
         line_valid[i] = 1'b0;
         line_key[i]   = '0;
         line_data[i]  = '0;
         line_age[i]   = RANK_W'(i);
      end
   endfunction

   function automatic void promote(input int slot);
      logic [RANK_W-1:0] was;
      was = line_age[slot];
      for (int i = 0; i < LINES; i++)
         if (line_age[i] < was) line_age[i] = line_age[i] + 1'b1;
      line_age[slot] = '0;
   endfunction

   function automatic cache_rsp_type access_line(input logic cmd,
                                                 input logic [KEY_IN_BITS-1:0] key,
                                                 input logic [DATA_BITS-1:0] din);
      cache_rsp_type     r;
      int                n;
      int                slot;
      logic [RANK_W-1:0] oldest;
      r.cmd      = cmd;
      r.key      = key;
      r.hit      = 1'b0;
      r.data_out = '0;
      n          = ways_active();
      slot       = -1;
      if (key == '0) return r;
      for (int i = 0; i < n; i++)
         if (slot < 0 && line_valid[i] && line_key[i] == key) slot = i;
      if (slot >= 0) begin
         r.hit = 1'b1;
         if (cmd == CMD_GET) r.data_out = line_data[slot];
         else line_data[slot] = din;
         promote(slot);
         return r;
      end
      if (cmd == CMD_GET) return r;
      // free lines fill lowest first, otherwise the oldest active line goes
      for (int i = 0; i < n; i++)
         if (slot < 0 && !line_valid[i]) slot = i;
      if (slot < 0) begin
         slot   = 0;
         oldest = '0;
         for (int i = 0; i < n; i++)
            if (line_age[i] >= oldest) begin
               oldest = line_age[i];
               slot   = i;
            end
      end
      line_valid[slot] = 1'b1;
      line_key[slot]   = key;
      line_data[slot]  = din;
      promote(slot);
      return r;
   endfunction

   function automatic int idle_gap();
      int r;
      if (quiet_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(16, 60);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // request driver
   int req_gap = 0;
   always @(posedge clock) begin : req_driver
      cache_req_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            item = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= item.cmd;
            req_tdata  <= {item.data_in, item.key};
            req_gap = idle_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready, with an occasional long hold to back the block up
   int rsp_taken  = 0;
   int hold_left  = 0;
   int stall_left = 0;
   always @(posedge clock) begin : rsp_ready_gen
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken++;
            if (rsp_taken % 500 == 250) hold_left = LONG_HOLD;
            stall_left = idle_gap();
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // check results first, then predict the request taken on the same edge
   always @(posedge clock) begin : monitor
      cache_rsp_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch($sformatf("result with nothing pending: hit %0b data %02h",
                                         rsp_tuser, rsp_tdata));
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_tuser !== want.hit)
                  report_mismatch($sformatf("cmd %0b key %04h: hit %0b, want %0b",
                                            want.cmd, want.key, rsp_tuser, want.hit));
               if (rsp_tdata !== want.data_out)
                  report_mismatch($sformatf("cmd %0b key %04h: data_out %02h, want %02h",
                                            want.cmd, want.key, rsp_tdata, want.data_out));
            end
         end
         if (req_tvalid && req_tready)
            expected_rsps.push_back(access_line(req_tuser, req_tdata[KEY_IN_BITS-1:0],
                                                req_tdata[KEY_IN_BITS+DATA_BITS-1:KEY_IN_BITS]));
      end
   end

   int idle_cycles = 0;
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("lru_block_cache_tb: FAIL");
            $finish;
         end
      end
   end

   task automatic add_req(input logic cmd, input logic [KEY_IN_BITS-1:0] key,
                          input logic [DATA_BITS-1:0] din);
      cache_req_type item;
      item.cmd     = cmd;
      item.key     = key;
      item.data_in = din;
      pending_reqs.push_back(item);
   endtask

   // keys mostly drawn from a small pool so that lines are hit, updated and evicted
   task automatic add_random_reqs(input int count);
      logic [KEY_IN_BITS-1:0] pool [$];
      int                     pool_size;
      int                     pick;
      logic [KEY_IN_BITS-1:0] key;
      pool_size = $urandom_range(1, 2 * ways_active() + 3);
      repeat (pool_size) pool.push_back(KEY_IN_BITS'($urandom_range(1, 65535)));
      if ($urandom_range(0, 3) == 0) pool[0] = '1;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) key = '0;
         else if (pick < 13) key = KEY_IN_BITS'($urandom);
         else key = pool[$urandom_range(0, pool_size - 1)];
         add_req(($urandom_range(0, 99) < 45) ? CMD_PUT : CMD_GET, key, DATA_BITS'($urandom));
      end
   endtask

   task automatic set_entries(input logic [CFG_BITS-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      ways_setting = value;
      flush_lines();
      @(negedge clock);
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   initial begin : stimulus
      int left;
      int phase;
      int chunk;
      flush_lines();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty cache at the reset size, key zero, update of a hit
      add_req(CMD_GET, 16'h1234, 8'h00);
      add_req(CMD_GET, 16'h0000, 8'h00);
      add_req(CMD_PUT, 16'h0000, 8'hAB);
      add_req(CMD_PUT, 16'hFFFF, 8'hFF);
      add_req(CMD_GET, 16'hFFFF, 8'h00);
      add_req(CMD_PUT, 16'hFFFF, 8'h00);
      add_req(CMD_GET, 16'hFFFF, 8'hFF);
      add_req(CMD_GET, 16'h0000, 8'h00);
      drain();

      // three lines: fill, reorder by a get, then evict the oldest twice
      set_entries(5'd3);
      add_req(CMD_PUT, 16'h0001, 8'hAA);
      add_req(CMD_PUT, 16'h0002, 8'h55);
      add_req(CMD_PUT, 16'h0004, 8'h0F);
      add_req(CMD_GET, 16'h0001, 8'h00);
      add_req(CMD_PUT, 16'h0008, 8'hF0);
      add_req(CMD_GET, 16'h0002, 8'h00);
      add_req(CMD_GET, 16'h0004, 8'h00);
      add_req(CMD_PUT, 16'h0010, 8'h3C);
      add_req(CMD_GET, 16'h0001, 8'h00);
      add_req(CMD_GET, 16'h0008, 8'h00);
      drain();

      // zero acts as a single line
      set_entries(5'd0);
      add_req(CMD_PUT, 16'h8000, 8'h11);
      add_req(CMD_GET, 16'h8000, 8'h00);
      add_req(CMD_PUT, 16'h7FFF, 8'h22);
      add_req(CMD_GET, 16'h8000, 8'h00);
      add_req(CMD_GET, 16'h7FFF, 8'h00);
      drain();

      left  = RANDOM_REQS;
      phase = 0;
      while (left > 0) begin
         if (phase < 6) set_entries(sweep_settings[phase]);
         else set_entries(CFG_BITS'($urandom_range(0, 31)));
         quiet_gaps = ($urandom_range(0, 3) == 0);
         chunk = $urandom_range(60, 220);
         if (chunk > left) chunk = left;
         add_random_reqs(chunk);
         left -= chunk;
         phase++;
         drain();
      end

      repeat (40) @(negedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("lru_block_cache_tb: PASS");
      end else begin
         $display("lru_block_cache_tb: FAIL");
      end
      $finish;
   end

endmodule

@@ lru_block_cache.f @@
hw/rtl/lbc_pkg.sv
hw/rtl/lbc_ctrl.sv
hw/rtl/lbc_datapath.sv
hw/rtl/lru_block_cache.sv
dv/lru_block_cache_tb.sv
